// ===== src/lzsd_pkg.sv =====
package lzsd_pkg;

   localparam int WINDOW_DEPTH_DEF = 1024;
   localparam int MATCH_MIN_LEN    = 3;

   typedef logic [1:0] err_type;

   localparam err_type ERR_NONE     = 2'd0;
   localparam err_type ERR_DISTANCE = 2'd1;
   localparam err_type ERR_OVERRUN  = 2'd2;
   localparam err_type ERR_EARLY    = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
      logic       frame_done;
      err_type    error;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic    hdr_load;
      logic    hdr_clear;
      logic    frame_start;
      logic    lit_load;
      logic    first_load;
      logic    match_setup;
      logic    lit_emit;
      logic    mem_read;
      logic    match_emit;
      logic    out_load;
      logic    out_has;
      logic    out_last;
      logic    out_done;
      err_type out_err;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hc_is3;
      logic size_zero;
      logic reach_size;
      logic lit_last;
      logic dist_bad;
      logic match_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== src/lzsd_ctrl.sv =====
module lzsd_ctrl
   import lzsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  req_type     req_data,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] ST_HEADER  = 3'd0;
   localparam logic [2:0] ST_CONTROL = 3'd1;
   localparam logic [2:0] ST_LITERAL = 3'd2;
   localparam logic [2:0] ST_MATCH2  = 3'd3;
   localparam logic [2:0] ST_MREAD   = 3'd4;
   localparam logic [2:0] ST_MEMIT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;
   logic       accept;

   assign req_ready = stat.out_free &&
                      (state_ff inside {ST_HEADER, ST_CONTROL, ST_LITERAL, ST_MATCH2});
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      cmd.out_err = ERR_NONE;
      case (state_ff)
         ST_HEADER: begin
            if (accept) begin
               cmd.hdr_load = 1'b1;
               if (stat.hc_is3) begin
                  cmd.hdr_clear   = 1'b1;
                  cmd.frame_start = 1'b1;
                  if (stat.size_zero) begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     cmd.out_done = 1'b1;
                  end else if (req_data.in_last) begin
                     cmd.out_load = 1'b1;
                     cmd.out_last = 1'b1;
                     cmd.out_err  = ERR_EARLY;
                  end else begin
                     state_in = ST_CONTROL;
                  end
               end else if (req_data.in_last) begin
                  cmd.hdr_clear = 1'b1;
                  cmd.out_load  = 1'b1;
                  cmd.out_last  = 1'b1;
                  cmd.out_err   = ERR_EARLY;
               end
            end
         end
         ST_CONTROL: begin
            if (accept) begin
               if (req_data.in_byte[7]) begin
                  cmd.first_load = 1'b1;
                  state_in       = ST_MATCH2;
               end else begin
                  cmd.lit_load = 1'b1;
                  state_in     = ST_LITERAL;
               end
               if (req_data.in_last) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_err  = ERR_EARLY;
                  state_in     = ST_HEADER;
               end
            end
         end
         ST_LITERAL: begin
            if (accept) begin
               cmd.lit_emit = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_has  = 1'b1;
               cmd.out_last = 1'b1;
               if (stat.reach_size) begin
                  cmd.out_done = stat.lit_last;
                  cmd.out_err  = stat.lit_last ? ERR_NONE : ERR_OVERRUN;
                  state_in     = ST_HEADER;
               end else if (req_data.in_last) begin
                  cmd.out_err = ERR_EARLY;
                  state_in    = ST_HEADER;
               end else if (stat.lit_last) begin
                  state_in = ST_CONTROL;
               end
            end
         end
         ST_MATCH2: begin
            if (accept) begin
               if (stat.dist_bad) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_err  = ERR_DISTANCE;
                  state_in     = ST_HEADER;
               end else begin
                  cmd.match_setup = 1'b1;
                  fin_in          = req_data.in_last;
                  state_in        = ST_MREAD;
               end
            end
         end
         ST_MREAD: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_MEMIT;
         end
         ST_MEMIT: begin
            // hold the read data until the output register frees up
            if (stat.out_free) begin
               cmd.match_emit = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_has    = 1'b1;
               if (stat.reach_size) begin
                  cmd.out_last = 1'b1;
                  cmd.out_done = stat.match_last;
                  cmd.out_err  = stat.match_last ? ERR_NONE : ERR_OVERRUN;
                  state_in     = ST_HEADER;
               end else if (stat.match_last) begin
                  cmd.out_last = 1'b1;
                  if (fin_ff) begin
                     cmd.out_err = ERR_EARLY;
                     state_in    = ST_HEADER;
                  end else begin
                     state_in = ST_CONTROL;
                  end
               end else begin
                  state_in = ST_MREAD;
               end
            end
         end
         default: begin
            state_in = ST_HEADER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ===== src/lzsd_datapath.sv =====
module lzsd_datapath
   import lzsd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int AW  = $clog2(WINDOW_DEPTH);
   localparam int AW1 = AW + 1;

   logic [7:0]    window_ff [WINDOW_DEPTH];
   logic [7:0]    rdata_ff;

   logic [1:0]    hc_ff, hc_in;
   logic [31:0]   total_ff, total_in;
   logic [31:0]   produced_ff, produced_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [7:0]    lit_left_ff, lit_left_in;
   logic [5:0]    match_left_ff, match_left_in;
   logic [7:0]    first_ff, first_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [10:0]   match_dist;
   logic [5:0]    match_len;
   logic [AW:0]   diff;
   logic [AW:0]   diff_wrap;
   logic          emit;
   logic [7:0]    emit_byte;

   assign match_dist = {1'b0, first_ff[1:0], req_data.in_byte} + 11'd1;
   assign match_len  = {1'b0, first_ff[6:2]} + 6'(MATCH_MIN_LEN);
   assign diff       = {1'b0, wp_ff} - AW1'(match_dist);
   assign diff_wrap  = diff + AW1'(WINDOW_DEPTH);

   assign emit      = cmd.lit_emit || cmd.match_emit;
   assign emit_byte = cmd.lit_emit ? req_data.in_byte : rdata_ff;

   assign stat.hc_is3     = (hc_ff == 2'd3);
   assign stat.size_zero  = (req_data.in_byte == 8'd0) && (total_ff[31:8] == 24'd0);
   assign stat.reach_size = ((produced_ff + 32'd1) == total_ff);
   assign stat.lit_last   = (lit_left_ff == 8'd1);
   assign stat.dist_bad   = (produced_ff < 32'(match_dist));
   assign stat.match_last = (match_left_ff == 6'd1);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      hc_in         = hc_ff;
      total_in      = total_ff;
      produced_in   = produced_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      lit_left_in   = lit_left_ff;
      match_left_in = match_left_ff;
      first_in      = first_ff;

      if (cmd.hdr_load) begin
         // little-endian size: shift each header byte in from the top
         total_in = {req_data.in_byte, total_ff[31:8]};
         hc_in    = hc_ff + 2'd1;
      end
      if (cmd.hdr_clear) begin
         hc_in = 2'd0;
      end

      if (cmd.frame_start) begin
         produced_in = 32'd0;
         wp_in       = '0;
      end else if (emit) begin
         produced_in = produced_ff + 32'd1;
         wp_in       = (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end

      if (cmd.lit_load) begin
         lit_left_in = {1'b0, req_data.in_byte[6:0]} + 8'd1;
      end else if (cmd.lit_emit) begin
         lit_left_in = lit_left_ff - 8'd1;
      end

      if (cmd.first_load) begin
         first_in = req_data.in_byte;
      end

      if (cmd.match_setup) begin
         match_left_in = match_len;
         rp_in         = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
      end else if (cmd.match_emit) begin
         match_left_in = match_left_ff - 6'd1;
         rp_in         = (rp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_byte   = cmd.out_has ? emit_byte : 8'd0;
         rsp_data_in.has_byte   = cmd.out_has;
         rsp_data_in.last       = cmd.out_last;
         rsp_data_in.frame_done = cmd.out_done;
         rsp_data_in.error      = cmd.out_err;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         window_ff[wp_ff] <= emit_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rdata_ff <= window_ff[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= 2'd0;
         produced_ff  <= 32'd0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hc_ff        <= hc_in;
         produced_ff  <= produced_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff      <= total_in;
      rp_ff         <= rp_in;
      lit_left_ff   <= lit_left_in;
      match_left_ff <= match_left_in;
      first_ff      <= first_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/lzss_stream_decompressor_top.sv =====
// LZSS stream decompressor: takes one compressed byte per req beat and returns the
// decompressed bytes on rsp, with frame_done and error codes on the final beat of the
// byte that caused them. Header, control and literal bytes are taken one per cycle
// while the output register can accept a beat. A match stalls req: after the match
// byte, each copied byte is a registered read of the single-port history window, then
// the emit and window write, so req stays stalled until the whole copy is out. The
// window holds WINDOW_DEPTH bytes and needs no clearing after reset.
module lzss_stream_decompressor_top
   import lzsd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lzsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzsd_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_lzss_stream_decompressor_top.sv =====
`timescale 1ns / 100ps

module tb_lzss_stream_decompressor_top;
   import lzsd_pkg::*;

   localparam int RUN_LIMIT       = 400000;
   localparam int DRAIN_WAIT      = 80;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_BEATS     = 20;

   typedef enum logic [1:0] {ST_HEADER, ST_CONTROL, ST_LITERAL, ST_MATCH2} dec_state_type;

   typedef struct packed {
      req_type beat;
      logic    pinned;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   lzss_stream_decompressor_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // decoder mirror
   dec_state_type dec_state;
   int unsigned   hdr_cnt;
   logic [31:0]   decl_size;
   logic [31:0]   out_cnt;
   int unsigned   lit_left;
   logic [7:0]    match_ctl;
   logic [7:0]    hist_mem [0:WINDOW_DEPTH_DEF-1];

   rsp_type      step_out[$];
   rsp_type      pending_out[$];
   stim_row_type stim_q[$];
   stim_row_type cur_row;

   int send_idle_pct;
   int rsp_idle_pct;
   bit hold_off_req;

   int fail_cnt       = 0;
   int beats_in       = 0;
   int beats_out      = 0;
   int frames_done    = 0;
   int frames_aborted = 0;
   int cycle_cnt      = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t (result beat %0d): %s", $time, beats_out, what);
      fail_cnt++;
   endtask

   function automatic rsp_type mk_rsp(input logic [7:0] b, input logic has, input logic done,
                                      input err_type err);
      rsp_type r;
      r.out_byte   = b;
      r.has_byte   = has;
      r.last       = 1'b1;
      r.frame_done = done;
      r.error      = err;
      return r;
   endfunction

   function automatic void emit_out(input logic [7:0] v);
      rsp_type r;
      hist_mem[out_cnt % WINDOW_DEPTH_DEF] = v;
      out_cnt++;
      r = '0;
      r.out_byte = v;
      r.has_byte = 1'b1;
      step_out.insert(step_out.size(), r);
   endfunction

   // Fill step_out with the beats one compressed byte should produce.
   function automatic void decode_beat(input req_type beat);
      logic [7:0] b;
      int         mlen;
      int         mdist;
      int         i;
      bit         stop;
      bit         done;
      err_type    err;
      rsp_type    r;
      b    = beat.in_byte;
      done = 1'b0;
      err  = ERR_NONE;
      step_out.delete();
      case (dec_state)
         ST_HEADER: begin
            if (hdr_cnt == 0) decl_size = '0;
            decl_size[hdr_cnt*8 +: 8] = b;
            if (hdr_cnt == 3) begin
               hdr_cnt  = 0;
               out_cnt  = '0;
               lit_left = 0;
               if (decl_size == 0) done = 1'b1;
               else dec_state = ST_CONTROL;
            end else begin
               hdr_cnt++;
            end
         end
         ST_CONTROL: begin
            if (b[7]) begin
               match_ctl = b;
               dec_state = ST_MATCH2;
            end else begin
               lit_left  = b[6:0] + 1;
               dec_state = ST_LITERAL;
            end
         end
         ST_LITERAL: begin
            emit_out(b);
            lit_left--;
            if (out_cnt == decl_size) begin
               if (lit_left != 0) err = ERR_OVERRUN;
               else done = 1'b1;
               dec_state = ST_HEADER;
               lit_left  = 0;
            end else if (lit_left == 0) begin
               dec_state = ST_CONTROL;
            end
         end
         ST_MATCH2: begin
            mlen      = match_ctl[6:2] + MATCH_MIN_LEN;
            mdist     = {match_ctl[1:0], b} + 1;
            dec_state = ST_CONTROL;
            if (mdist > out_cnt) begin
               err       = ERR_DISTANCE;
               dec_state = ST_HEADER;
            end else begin
               i    = 0;
               stop = 1'b0;
               while (!stop && i < mlen) begin
                  emit_out(hist_mem[(out_cnt - mdist) % WINDOW_DEPTH_DEF]);
                  if (out_cnt == decl_size) begin
                     if (i + 1 < mlen) err = ERR_OVERRUN;
                     else done = 1'b1;
                     dec_state = ST_HEADER;
                     stop      = 1'b1;
                  end
                  i++;
               end
            end
         end
         default: begin
            dec_state = ST_HEADER;
            hdr_cnt   = 0;
         end
      endcase

      if (beat.in_last && err == ERR_NONE && !(dec_state == ST_HEADER && hdr_cnt == 0))
         err = ERR_EARLY;
      if (err != ERR_NONE) begin
         dec_state = ST_HEADER;
         hdr_cnt   = 0;
         lit_left  = 0;
      end
      // flags ride on the last byte, or on a bare beat when nothing was emitted
      if (err != ERR_NONE || done) begin
         if (step_out.size() == 0) begin
            r = '0;
            step_out.insert(step_out.size(), r);
         end
         r = step_out[step_out.size()-1];
         r.frame_done = done;
         r.error      = err;
         step_out[step_out.size()-1] = r;
      end
      if (step_out.size() != 0) begin
         r = step_out[step_out.size()-1];
         r.last = 1'b1;
         step_out[step_out.size()-1] = r;
      end
   endfunction

   function automatic void add_beat(input logic [7:0] b, input logic fin);
      stim_row_type r;
      r = '0;
      r.beat.in_byte = b;
      r.beat.in_last = fin;
      stim_q.insert(stim_q.size(), r);
   endfunction

   function automatic void add_pinned(input logic [7:0] b, input logic fin, input rsp_type want);
      stim_row_type r;
      r.beat.in_byte = b;
      r.beat.in_last = fin;
      r.pinned       = 1'b1;
      r.want         = want;
      stim_q.insert(stim_q.size(), r);
   endfunction

   function automatic void add_match(input int len, input int span);
      logic [4:0] lcode;
      logic [9:0] dcode;
      lcode = 5'(len - MATCH_MIN_LEN);
      dcode = 10'(span - 1);
      add_beat({1'b1, lcode, dcode[9:8]}, 1'b0);
      add_beat(dcode[7:0], 1'b0);
   endfunction

   // Mostly well-formed frames; some flavors break them on purpose.
   task automatic gen_frame();
      int           flavor;
      int           size;
      int           made;
      int           room;
      int           cap;
      int           n;
      int           len;
      int           k;
      bit           quit;
      logic [31:0]  sz;
      stim_row_type r;
      flavor = $urandom_range(15);
      size   = $urandom_range(1, 32);
      if (flavor == 0) begin
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++) add_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
      end else if (flavor == 1) begin
         // size no stream here can reach; cut the input short
         sz     = $urandom;
         sz[31] = 1'b1;
         for (k = 0; k < 4; k++) add_beat(sz[k*8 +: 8], 1'b0);
         n = $urandom_range(0, 4);
         for (k = 0; k < n; k++) add_beat(8'($urandom_range(255)), 1'b0);
         add_beat(8'($urandom_range(255)), 1'b1);
      end else begin
         sz = size;
         for (k = 0; k < 4; k++) add_beat(sz[k*8 +: 8], 1'b0);
         made = 0;
         quit = 1'b0;
         while (!quit && made < size) begin
            room = size - made;
            if (flavor == 2 && made > 0 && $urandom_range(3) == 0) begin
               // reach back past the start of the frame
               cap  = (made + 40 > WINDOW_DEPTH_DEF) ? WINDOW_DEPTH_DEF : made + 40;
               add_match($urandom_range(MATCH_MIN_LEN, 34), $urandom_range(made + 1, cap));
               quit = 1'b1;
            end else if (flavor == 3 && $urandom_range(4) == 0) begin
               add_beat(8'($urandom_range(127)), 1'b1);
               quit = 1'b1;
            end else if (made > 0 && room >= MATCH_MIN_LEN && $urandom_range(1) == 0) begin
               cap = (room < 34) ? room : 34;
               len = $urandom_range(MATCH_MIN_LEN, cap);
               if (flavor == 4 && room < 34 && $urandom_range(1) == 0)
                  len = $urandom_range(room + 1, 34);
               cap = (made < WINDOW_DEPTH_DEF) ? made : WINDOW_DEPTH_DEF;
               add_match(len, $urandom_range(1, cap));
               made += len;
            end else begin
               cap = ($urandom_range(3) == 0) ? 128 : 12;
               if (cap > room) cap = room;
               n = $urandom_range(1, cap);
               if (flavor == 4 && room < 128 && $urandom_range(1) == 0)
                  n = $urandom_range(room + 1, 128);
               add_beat(8'(n - 1), 1'b0);
               if (n > room) n = room;
               for (k = 0; k < n; k++) add_beat(8'($urandom_range(255)), 1'b0);
               made += n;
            end
         end
         // a clean frame may also close the input
         if (!quit && $urandom_range(3) == 0) begin
            r = stim_q[stim_q.size()-1];
            r.beat.in_last = 1'b1;
            stim_q[stim_q.size()-1] = r;
         end
      end
   endtask

   task automatic send_rows();
      stim_row_type row;
      while (stim_q.size() != 0) begin
         row = stim_q.pop_front();
         if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
         end
         cur_row = row;
         req_valid <= 1'b1;
         req_data  <= row.beat;
         do @(posedge clock); while (req_ready !== 1'b1);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   initial begin : rsp_drive
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_beats
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_beat(req_data);
            beats_in++;
            if (cur_row.pinned) pending_out.insert(pending_out.size(), cur_row.want);
            else while (step_out.size() != 0)
               pending_out.insert(pending_out.size(), step_out.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (pending_out.size() == 0) begin
               report_mismatch($sformatf("beat %h with nothing expected", rsp_data));
            end else begin
               want = pending_out.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, want %h",
                                            rsp_data.out_byte, want.out_byte));
               if (rsp_data.has_byte !== want.has_byte)
                  report_mismatch($sformatf("has_byte %b, want %b",
                                            rsp_data.has_byte, want.has_byte));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_data.last, want.last));
               if (rsp_data.frame_done !== want.frame_done)
                  report_mismatch($sformatf("frame_done %b, want %b",
                                            rsp_data.frame_done, want.frame_done));
               if (rsp_data.error !== want.error)
                  report_mismatch($sformatf("error %0d, want %0d", rsp_data.error, want.error));
               if (want.frame_done) frames_done++;
               if (want.error != ERR_NONE) frames_aborted++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_cnt, pending_out.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : main_seq
      int k;
      int ph;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      hold_off_req  = 1'b0;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      dec_state     = ST_HEADER;
      hdr_cnt       = 0;
      decl_size     = '0;
      out_cnt       = '0;
      lit_left      = 0;
      match_ctl     = '0;
      for (k = 0; k < WINDOW_DEPTH_DEF; k++) hist_mem[k] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 33;
               rsp_idle_pct  = 51;
               // empty frame; its closing byte also ends the input without error
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_pinned(8'h00, 1'b1, mk_rsp(8'h00, 1'b0, 1'b1, ERR_NONE));
               // four-byte frame: one literal, then a length-3 copy at distance 1
               add_beat(8'h04, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'hFF, 1'b0);
               add_beat(8'h80, 1'b0);
               add_beat(8'h00, 1'b0);
               // longest, farthest match before anything was produced
               add_beat(8'h02, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'hFF, 1'b0);
               add_pinned(8'hFF, 1'b0, mk_rsp(8'h00, 1'b0, 1'b0, ERR_DISTANCE));
               // 128-byte literal run into a one-byte frame
               add_beat(8'h01, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h00, 1'b0);
               add_beat(8'h7F, 1'b0);
               add_pinned(8'h5A, 1'b0, mk_rsp(8'h5A, 1'b1, 1'b0, ERR_OVERRUN));
               // input ends inside a header
               add_pinned(8'h11, 1'b1, mk_rsp(8'h00, 1'b0, 1'b0, ERR_EARLY));
            end
            1: begin
               send_idle_pct = 51;
               rsp_idle_pct  = 33;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
               // back up the output while input keeps coming
               hold_off_req  = 1'b1;
            end
         endcase
         while (stim_q.size() < PHASE_BEATS + (ph == 0 ? 25 : 0)) begin
            gen_frame();
         end
         send_rows();
         do @(negedge clock); while (pending_out.size() != 0);
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_out.size() != 0)
         report_mismatch($sformatf("%0d expected beats never arrived", pending_out.size()));
      $display("covered %0d compressed bytes and %0d result beats under three stall mixes",
               beats_in, beats_out);
      $display("%0d frames closed, %0d abandoned on error, %0d mismatches",
               frames_done, frames_aborted, fail_cnt);
      if (fail_cnt == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/lzsd_pkg.sv
src/lzsd_ctrl.sv
src/lzsd_datapath.sv
src/lzss_stream_decompressor_top.sv
tb/tb_lzss_stream_decompressor_top.sv
